// ----- sv/bencst_pkg.sv -----
// Shared constants, codes and types for the bencode stream tokenizer.
// Depends on nothing; every other file of the block imports this package.
package bencst_pkg;

    localparam int DEF_MAX_DEPTH   = 32;
    localparam int DEF_LENGTH_BITS = 32;

    // Bytes with a fixed meaning in the bencode grammar.
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Parse phases.
    localparam logic [1:0] PH_VALUE = 2'd0;
    localparam logic [1:0] PH_LEN   = 2'd1;
    localparam logic [1:0] PH_BODY  = 2'd2;
    localparam logic [1:0] PH_INT   = 2'd3;

    // Container kinds held on the stack; CK_NONE stands for an empty stack.
    localparam logic [1:0] CK_LIST = 2'd0;
    localparam logic [1:0] CK_DKEY = 2'd1;
    localparam logic [1:0] CK_DVAL = 2'd2;
    localparam logic [1:0] CK_NONE = 2'd3;

    // Token kinds.
    localparam logic [2:0] TK_LIST_OPEN = 3'd0;
    localparam logic [2:0] TK_DICT_OPEN = 3'd1;
    localparam logic [2:0] TK_CLOSE     = 3'd2;
    localparam logic [2:0] TK_STR_HDR   = 3'd3;
    localparam logic [2:0] TK_STR_BYTE  = 3'd4;
    localparam logic [2:0] TK_INTEGER   = 3'd5;
    localparam logic [2:0] TK_ERROR     = 3'd6;

    // Error codes.
    localparam logic [2:0] ER_NONE      = 3'd0;
    localparam logic [2:0] ER_BAD_START = 3'd1;
    localparam logic [2:0] ER_BAD_LEN   = 3'd2;
    localparam logic [2:0] ER_BAD_INT   = 3'd3;
    localparam logic [2:0] ER_INT_OVF   = 3'd4;
    localparam logic [2:0] ER_LEN_OVF   = 3'd5;
    localparam logic [2:0] ER_KEY       = 3'd6;
    localparam logic [2:0] ER_DEEP      = 3'd7;

    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] value;
        logic        key;
        logic        last;
        logic [5:0]  depth;
        logic        complete;
        logic [2:0]  code;
    } t_token;

    // Stack command: clear applies first, then push or pop, then flip of the
    // resulting top entry (dictionary key and value alternate).
    typedef struct packed {
        logic       clear;
        logic       push;
        logic       pop;
        logic       flip;
        logic [1:0] kind;
    } t_stk_cmd;

endpackage

// ----- sv/bencst_stack.sv -----
// Container-kind stack: the top entry sits in a register, the entries below
// it in a synchronous memory with a registered read and write forwarding.
// Depends on bencst_pkg.
module bencst_stack #(
    parameter int MAX_DEPTH = 32,
    parameter int DW        = 6
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bencst_pkg::t_stk_cmd i_cmd,
    output logic [DW-1:0]        o_depth,
    output logic [1:0]           o_top
);
    import bencst_pkg::*;

    localparam int ADDR_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    logic [1:0]        mem [2**ADDR_W];
    logic [DW-1:0]     r_depth, n_depth;
    logic [1:0]        r_top, n_top, top_pre;
    logic [DW-1:0]     base_depth;
    logic              we;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [DW+1:0]     raddr_full;
    logic [1:0]        r_rd_data, r_fwd_data, below;
    logic              r_fwd;

    always_comb begin
        base_depth = i_cmd.clear ? '0 : r_depth;
        we         = i_cmd.push && (base_depth != '0);
        waddr      = ADDR_W'(base_depth - DW'(1));
        below      = r_fwd ? r_fwd_data : r_rd_data;

        n_depth = base_depth;
        top_pre = r_top;
        if (i_cmd.push) begin
            n_depth = base_depth + DW'(1);
            top_pre = i_cmd.kind;
        end else if (i_cmd.pop) begin
            n_depth = base_depth - DW'(1);
            top_pre = below;
        end

        n_top = top_pre;
        if (i_cmd.flip) begin
            if (top_pre == CK_DKEY) begin
                n_top = CK_DVAL;
            end else if (top_pre == CK_DVAL) begin
                n_top = CK_DKEY;
            end
        end

        // The entry under the new top lives two below the new depth.
        raddr_full = {2'b00, n_depth} - (DW+2)'(2);
        raddr      = raddr_full[ADDR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
            r_fwd   <= 1'b0;
        end else begin
            r_depth <= n_depth;
            r_fwd   <= we && (waddr == raddr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= r_top;
        end
        r_rd_data  <= mem[raddr];
        r_fwd_data <= r_top;
        r_top      <= n_top;
    end

    assign o_depth = r_depth;
    assign o_top   = r_top;

    a_depth_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DW'(MAX_DEPTH))
        else $error("stack depth beyond its limit");

    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.push && i_cmd.pop))
        else $error("push and pop in the same cycle");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> (base_depth != '0))
        else $error("pop of an empty stack");

    a_push_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |=> (r_top == $past(i_cmd.kind)))
        else $error("pushed kind not on top");

endmodule

// ----- sv/bencst_parse.sv -----
// Per-byte parse step: phase, number accumulator, string length and flags,
// issuing stack commands and at most one token per byte.
// Depends on bencst_pkg.
module bencst_parse #(
    parameter int MAX_DEPTH   = 32,
    parameter int LENGTH_BITS = 32,
    parameter int DW          = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_restart,
    input  logic [DW-1:0]         i_depth,
    input  logic [1:0]            i_top,
    output bencst_pkg::t_stk_cmd  o_cmd,
    output logic                  o_res_valid,
    output bencst_pkg::t_token    o_res
);
    import bencst_pkg::*;

    localparam logic [67:0] LEN_LIMIT = (68'(1) << LENGTH_BITS) - 68'(1);
    localparam logic [67:0] POS_LIMIT = (68'(1) << 63) - 68'(1);
    localparam logic [67:0] NEG_LIMIT = 68'(1) << 63;

    logic [1:0]             r_phase, n_phase, phase_e;
    logic [63:0]            r_acc, n_acc;
    logic [LENGTH_BITS-1:0] r_rem, n_rem;
    logic                   r_neg, n_neg, neg_e;
    logic                   r_seen, n_seen, seen_e;
    logic                   r_halt, n_halt, halt_e;
    logic [DW-1:0]          depth_e, depth_after;
    logic [1:0]             top_e;
    logic                   isdig, key;
    logic [3:0]             digit;
    logic [67:0]            prod, int_limit;

    always_comb begin
        isdig  = (i_data_byte >= CH_ZERO) && (i_data_byte <= CH_NINE);
        digit  = isdig ? 4'(i_data_byte - CH_ZERO) : 4'd0;
        // acc * 10 + digit, kept wide so that overflow is a plain compare.
        prod   = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) + 68'(digit);

        phase_e = i_restart ? PH_VALUE : r_phase;
        neg_e   = i_restart ? 1'b0 : r_neg;
        seen_e  = i_restart ? 1'b0 : r_seen;
        halt_e  = i_restart ? 1'b0 : r_halt;
        depth_e = i_restart ? '0 : i_depth;
        top_e   = (depth_e == '0) ? CK_NONE : i_top;
        key     = (top_e == CK_DKEY);
        int_limit   = neg_e ? NEG_LIMIT : POS_LIMIT;
        depth_after = depth_e;

        n_phase = r_phase;
        n_acc   = r_acc;
        n_rem   = r_rem;
        n_neg   = r_neg;
        n_seen  = r_seen;
        n_halt  = r_halt;

        o_cmd       = '0;
        o_cmd.clear = i_accept && i_restart;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_accept) begin
            n_phase = phase_e;
            n_neg   = neg_e;
            n_seen  = seen_e;
            n_halt  = halt_e;
        end

        if (i_accept && !halt_e) begin
            unique case (phase_e)
                PH_VALUE: begin
                    if (i_data_byte == CH_E) begin
                        if (depth_e == '0 || top_e == CK_DVAL) begin
                            o_res_valid = 1'b1;
                            o_res.kind  = TK_ERROR;
                            o_res.code  = ER_BAD_START;
                            n_halt      = 1'b1;
                        end else begin
                            o_cmd.pop      = 1'b1;
                            depth_after    = depth_e - DW'(1);
                            o_res_valid    = 1'b1;
                            o_res.kind     = TK_CLOSE;
                            o_res.complete = (depth_after == '0);
                            o_cmd.flip     = (depth_after != '0);
                            n_halt         = (depth_after == '0);
                        end
                    end else if (top_e == CK_DKEY && !isdig) begin
                        o_res_valid = 1'b1;
                        o_res.kind  = TK_ERROR;
                        o_res.code  = ER_KEY;
                        n_halt      = 1'b1;
                    end else if (isdig) begin
                        n_acc   = 64'(digit);
                        n_phase = PH_LEN;
                    end else if (i_data_byte == CH_I) begin
                        n_acc   = '0;
                        n_neg   = 1'b0;
                        n_seen  = 1'b0;
                        n_phase = PH_INT;
                    end else if (i_data_byte == CH_L || i_data_byte == CH_D) begin
                        o_res_valid = 1'b1;
                        if (depth_e >= DW'(MAX_DEPTH)) begin
                            o_res.kind = TK_ERROR;
                            o_res.code = ER_DEEP;
                            n_halt     = 1'b1;
                        end else begin
                            o_cmd.push  = 1'b1;
                            o_cmd.kind  = (i_data_byte == CH_L) ? CK_LIST : CK_DKEY;
                            depth_after = depth_e + DW'(1);
                            o_res.kind  = (i_data_byte == CH_L) ? TK_LIST_OPEN
                                                                : TK_DICT_OPEN;
                        end
                    end else begin
                        o_res_valid = 1'b1;
                        o_res.kind  = TK_ERROR;
                        o_res.code  = ER_BAD_START;
                        n_halt      = 1'b1;
                    end
                end
                PH_LEN: begin
                    if (isdig) begin
                        if (prod > LEN_LIMIT) begin
                            o_res_valid = 1'b1;
                            o_res.kind  = TK_ERROR;
                            o_res.code  = ER_LEN_OVF;
                            n_halt      = 1'b1;
                        end else begin
                            n_acc = prod[63:0];
                        end
                    end else if (i_data_byte == CH_COLON) begin
                        o_res_valid = 1'b1;
                        o_res.kind  = TK_STR_HDR;
                        o_res.key   = key;
                        if (r_acc == '0) begin
                            // An empty string ends its value at the header.
                            o_res.last     = 1'b1;
                            o_res.complete = (depth_e == '0);
                            o_cmd.flip     = (depth_e != '0);
                            n_halt         = (depth_e == '0);
                            n_phase        = PH_VALUE;
                        end else begin
                            o_res.value = r_acc;
                            n_rem       = r_acc[LENGTH_BITS-1:0];
                            n_phase     = PH_BODY;
                        end
                    end else begin
                        o_res_valid = 1'b1;
                        o_res.kind  = TK_ERROR;
                        o_res.code  = ER_BAD_LEN;
                        n_halt      = 1'b1;
                    end
                end
                PH_BODY: begin
                    o_res_valid = 1'b1;
                    o_res.kind  = TK_STR_BYTE;
                    o_res.value = {56'b0, i_data_byte};
                    o_res.key   = key;
                    n_rem       = r_rem - LENGTH_BITS'(1);
                    if (r_rem == LENGTH_BITS'(1)) begin
                        o_res.last     = 1'b1;
                        o_res.complete = (depth_e == '0);
                        o_cmd.flip     = (depth_e != '0);
                        n_halt         = (depth_e == '0);
                        n_phase        = PH_VALUE;
                    end
                end
                PH_INT: begin
                    if (i_data_byte == CH_MINUS && !seen_e && !neg_e) begin
                        n_neg = 1'b1;
                    end else if (isdig) begin
                        if (seen_e && r_acc == '0) begin
                            // Leading zero.
                            o_res_valid = 1'b1;
                            o_res.kind  = TK_ERROR;
                            o_res.code  = ER_BAD_INT;
                            n_halt      = 1'b1;
                        end else if (prod > int_limit) begin
                            o_res_valid = 1'b1;
                            o_res.kind  = TK_ERROR;
                            o_res.code  = ER_INT_OVF;
                            n_halt      = 1'b1;
                        end else begin
                            n_acc  = prod[63:0];
                            n_seen = 1'b1;
                        end
                    end else if (i_data_byte == CH_E) begin
                        o_res_valid = 1'b1;
                        if (!seen_e || (neg_e && r_acc == '0)) begin
                            o_res.kind = TK_ERROR;
                            o_res.code = ER_BAD_INT;
                            n_halt     = 1'b1;
                        end else begin
                            o_res.kind     = TK_INTEGER;
                            o_res.value    = neg_e ? (64'd0 - r_acc) : r_acc;
                            o_res.complete = (depth_e == '0);
                            o_cmd.flip     = (depth_e != '0);
                            n_halt         = (depth_e == '0);
                            n_phase        = PH_VALUE;
                        end
                    end else begin
                        o_res_valid = 1'b1;
                        o_res.kind  = TK_ERROR;
                        o_res.code  = ER_BAD_INT;
                        n_halt      = 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_VALUE;
                end
            endcase
        end

        o_res.depth = 6'(depth_after);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_VALUE;
            r_neg   <= 1'b0;
            r_seen  <= 1'b0;
            r_halt  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_seen  <= n_seen;
            r_halt  <= n_halt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_rem <= n_rem;
    end

endmodule

// ----- sv/bencst_outbuf.sv -----
// Two-entry output buffer (output register plus skid register) that keeps
// the byte input flowing while a single token waits on the output.
// Depends on bencst_pkg.
module bencst_outbuf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_res_valid,
    input  bencst_pkg::t_token i_res,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output bencst_pkg::t_token o_out
);
    import bencst_pkg::*;

    logic   r_out_v, r_skid_v;
    t_token r_out, r_skid;
    logic   load_out;

    assign load_out   = !r_out_v || i_out_ready;
    assign o_in_ready = !r_skid_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (load_out) begin
            r_out_v  <= r_skid_v || i_res_valid;
            r_skid_v <= r_skid_v && i_res_valid;
        end else if (i_res_valid) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= r_skid_v ? r_skid : i_res;
            if (r_skid_v) begin
                r_skid <= i_res;
            end
        end else if (i_res_valid) begin
            r_skid <= i_res;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out       = r_out;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry held with an empty output register");

    a_no_write_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> !i_res_valid)
        else $error("token produced while the buffer is full");

endmodule

// ----- sv/bencode_stream_tokenizer_core.sv -----
// Bencode stream tokenizer: at most one token per byte out. Bytes are taken one per
// cycle while o_in_ready is high; each token is registered in the output register,
// or in the skid register while the output stalls. The stack keeps up through its
// top register, the registered read of the memory below it and write forwarding.
// Reset (synchronous, active low) clears phase, flags, stack depth and output
// valids; the stack memory is not cleared and its contents are only used after being written.
module bencode_stream_tokenizer_core #(
    parameter int MAX_DEPTH   = bencst_pkg::DEF_MAX_DEPTH,
    parameter int LENGTH_BITS = bencst_pkg::DEF_LENGTH_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_data_byte,
    input  logic               i_restart,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [2:0]         o_token_kind,
    output logic signed [63:0] o_token_value,
    output logic               o_is_key,
    output logic               o_last_of_string,
    output logic [5:0]         o_nest_depth,
    output logic               o_value_complete,
    output logic [2:0]         o_error_code
);
    import bencst_pkg::*;

    localparam int DW = $clog2(MAX_DEPTH + 1);

    logic          accept;
    t_stk_cmd      stk_cmd;
    logic [DW-1:0] stk_depth;
    logic [1:0]    stk_top;
    logic          res_valid;
    t_token        res, out_tok;

    assign accept = i_in_valid && o_in_ready;

    bencst_stack #(
        .MAX_DEPTH (MAX_DEPTH),
        .DW        (DW)
    ) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (stk_cmd),
        .o_depth (stk_depth),
        .o_top   (stk_top)
    );

    bencst_parse #(
        .MAX_DEPTH   (MAX_DEPTH),
        .LENGTH_BITS (LENGTH_BITS),
        .DW          (DW)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_restart   (i_restart),
        .i_depth     (stk_depth),
        .i_top       (stk_top),
        .o_cmd       (stk_cmd),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    bencst_outbuf u_outbuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (out_tok)
    );

    assign o_token_kind     = out_tok.kind;
    assign o_token_value    = $signed(out_tok.value);
    assign o_is_key         = out_tok.key;
    assign o_last_of_string = out_tok.last;
    assign o_nest_depth     = out_tok.depth;
    assign o_value_complete = out_tok.complete;
    assign o_error_code     = out_tok.code;

endmodule
